@@ design/base64url_stream_encoder_top_macros.svh @@
// Assertion macros shared by the base64url encoder RTL.
`ifndef BASE64URL_STREAM_ENCODER_TOP_MACROS_SVH
`define BASE64URL_STREAM_ENCODER_TOP_MACROS_SVH
`ifndef SYNTH
// Check that a condition implies a consequence in the same cycle.
`define B64U_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b64u assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define B64U_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b64u assertion failed");
`else
`define B64U_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define B64U_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ design/b64u_pkg.sv @@
// Shared types and the character mapping for the base64url encoder.
package b64u_pkg;

  // Position of the next byte within its three-byte group.
  typedef enum logic [1:0] {
    PH_0 = 2'd0,
    PH_1 = 2'd1,
    PH_2 = 2'd2
  } phase_t;

  // One classified byte: one or two six-bit codes waiting to be emitted.
  typedef struct packed {
    logic [5:0] six0;
    logic [5:0] six1;
    logic       two;
    logic       last;
  } chunk_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChUnder  = 8'h5F;

  // Map a six-bit code onto the URL-safe alphabet.
  function automatic logic [7:0] b64u_char(input logic [5:0] v);
    logic [7:0] v8;
    logic [7:0] c;
    v8 = {2'b00, v};
    if (v < 6'd26) begin
      c = ChUpperA + v8;
    end else if (v < 6'd52) begin
      c = ChLowerA + v8 - 8'd26;
    end else if (v < 6'd62) begin
      c = ChZero + v8 - 8'd52;
    end else if (v == 6'd62) begin
      c = ChDash;
    end else begin
      c = ChUnder;
    end
    return c;
  endfunction

endpackage

@@ design/b64u_front.sv @@
// Front part: accepts bytes, tracks the group phase and splits bits into codes.
module b64u_front import b64u_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  q_stat_t    q_stat,
  output logic       push,
  output chunk_t     push_data
);

  phase_t     phase_r, phase_nxt;
  logic [3:0] left_r, left_nxt;

  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_data.last = in_last_byte;
    case (phase_r)
      PH_1: begin
        push_data.six0 = {left_r[1:0], in_data_byte[7:4]};
        push_data.six1 = {in_data_byte[3:0], 2'b00};
        push_data.two  = in_last_byte;
        phase_nxt      = PH_2;
        left_nxt       = in_data_byte[3:0];
      end
      PH_2: begin
        push_data.six0 = {left_r, in_data_byte[7:6]};
        push_data.six1 = in_data_byte[5:0];
        push_data.two  = 1'b1;
        phase_nxt      = PH_0;
        left_nxt       = 4'd0;
      end
      default: begin
        push_data.six0 = in_data_byte[7:2];
        push_data.six1 = {in_data_byte[1:0], 4'b0000};
        push_data.two  = in_last_byte;
        phase_nxt      = PH_1;
        left_nxt       = {2'b00, in_data_byte[1:0]};
      end
    endcase
    // drop the partial group at the end of a message
    if (in_last_byte) begin
      phase_nxt = PH_0;
      left_nxt  = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_0;
      left_r  <= 4'd0;
    end else if (push) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

@@ design/b64u_queue.sv @@
// Two-entry queue between the front and back parts.
`include "base64url_stream_encoder_top_macros.svh"
module b64u_queue import b64u_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  chunk_t  push_data,
  input  logic    pop,
  output chunk_t  head,
  output q_stat_t q_stat
);

  chunk_t     mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  `B64U_ASSERT_IMP(a_q_no_overflow, clk, rst_n, push, !q_stat.full)
  `B64U_ASSERT_IMP(a_q_no_underflow, clk, rst_n, pop, !q_stat.empty)
  `B64U_ASSERT_IMP(a_q_cnt_ptrs, clk, rst_n, cnt_r == 2'd1, wr_ptr_r != rd_ptr_r)

endmodule

@@ design/b64u_back.sv @@
// Back part: emits one character a cycle, while not stalled, from the queue head into the output register.
`include "base64url_stream_encoder_top_macros.svh"
module b64u_back import b64u_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  q_stat_t    q_stat,
  input  chunk_t     head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_run_end,
  output logic       out_message_end
);

  logic       sel_r, sel_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] char_r;
  logic       run_end_r;
  logic       msg_end_r;
  logic       load;
  logic       emit;
  logic       fin;
  logic [5:0] six;

  assign load = !out_valid_r || out_ready;
  assign emit = load && !q_stat.empty;
  assign fin  = !head.two || sel_r;
  assign pop  = emit && fin;
  assign six  = sel_r ? head.six1 : head.six0;

  always_comb begin
    out_valid_nxt = out_valid_r;
    sel_nxt       = sel_r;
    if (load) begin
      out_valid_nxt = !q_stat.empty;
    end
    if (emit) begin
      sel_nxt = !fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_r    <= b64u_char(six);
      run_end_r <= fin;
      msg_end_r <= fin && head.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char        = char_r;
  assign out_run_end     = run_end_r;
  assign out_message_end = msg_end_r;

  `B64U_ASSERT_IMP(a_bk_mid_entry_held, clk, rst_n, sel_r, !q_stat.empty && head.two)
  `B64U_ASSERT_IMP(a_bk_msg_implies_run, clk, rst_n, out_valid_r && msg_end_r, run_end_r)
  `B64U_ASSERT_NXT(a_bk_second_closes, clk, rst_n, emit && sel_r, !sel_r)

endmodule

@@ design/base64url_stream_encoder_top.sv @@
// Top level of the unpadded base64url stream encoder.
// Takes one byte per transaction with an end-of-message flag and returns URL-safe
// base64 characters (A-Z, a-z, 0-9, '-', '_'), one per output transaction, with no
// padding. A byte yields one character, or two when it completes a three-byte group
// or ends a message with a partial group (the spare bits are zero-filled).
// out_run_end marks the final character of each byte; out_message_end marks the
// final character of the message. The front part classifies a byte in the cycle it
// is accepted and hands it to a two-entry queue; the back part drains the queue
// head through the output register, one character per cycle while not stalled.
// Throughput is therefore set by that output register, which takes the characters
// of each byte one at a time. A byte is first written to a queue entry; its first
// character is then loaded into the output register before it appears. Input is
// taken while a finished character is still waiting at the output, as long as the
// queue has room.
module base64url_stream_encoder_top import b64u_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_run_end,
  output logic       out_message_end
);

  q_stat_t q_stat;
  chunk_t  push_data;
  chunk_t  head;
  logic    push;
  logic    pop;

  // classify bytes and track the group phase
  b64u_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_stat       (q_stat),
    .push         (push),
    .push_data    (push_data)
  );

  // decouple the two sides so each can stall on its own
  b64u_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // emit characters, one per cycle while not stalled, through the output register
  b64u_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_run_end     (out_run_end),
    .out_message_end (out_message_end)
  );

endmodule
